[rtl/itrd_pkg.sv]
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, constants and helpers for the integer-to-radix-digits core.
// ----------------------------------------------------------------------------
package itrd_pkg;

    localparam int MAX_DIGITS_DEF = 32;
    localparam int VALUE_BITS_DEF = 32;

    // bits of the quotient consumed per long-division cycle
    localparam int CHUNK_BITS = 8;

    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0]  CH_MINUS  = 7'd45;
    localparam logic [CHAR_W-1:0]  CH_ZERO   = 7'd48;
    localparam logic [CHAR_W-1:0]  CH_ALPHA  = 7'd65;
    localparam logic [CHAR_W-1:0]  CH_NINE   = 7'd57;
    localparam logic [CHAR_W-1:0]  CH_F      = 7'd70;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_POP,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load;   // capture a new request
        logic div;    // one chunk step of long division
        logic sign;   // emit '-'
        logic pop;    // pop one digit off the stack
    } cmd_t;

    typedef struct packed {
        logic div_done;  // this cycle finishes a digit and the quotient is zero
        logic negative;
        logic pop_last;  // one digit left on the stack
    } status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DIGIT_TEN)
        begin
            c = CH_ALPHA + CHAR_W'(d - DIGIT_TEN);
        end
        else
        begin
            c = CH_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

[rtl/integer_to_radix_digits_core.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core
// Signed integer to base-R ASCII text, most significant digit first.
//
//   channel   handshake          fields
//   -------   ----------------   ---------------------------
//   request   start / busy       value, radix
//   result    strobe (1 cycle)   char_code, last
//
// A request runs the long division (one 8-bit chunk of the quotient per
// cycle, from the top chunk down; the top chunk is dropped once it reaches
// zero, at most one chunk per digit), emits '-' for a negative value, and
// then pops the digits off the stack one per cycle.
// Reset is asynchronous; the digit stack needs no clearing pass.
// Results cannot be stalled; busy stays high until the last pop is out.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_core #(
    parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_BITS-1:0]  value,
    input  logic [itrd_pkg::RADIX_W-1:0]  radix,
    output logic                          strobe,
    output logic [itrd_pkg::CHAR_W-1:0]   char_code,
    output logic                          last
);

    itrd_pkg::cmd_t    cmd;
    itrd_pkg::status_t status;

    itrd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    itrd_datapath #(
        .MAX_DIGITS (MAX_DIGITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (value),
        .radix     (radix),
        .status    (status),
        .strobe    (strobe),
        .char_code (char_code),
        .last      (last)
    );

`ifndef SYNTHESIS
    // final character lands after the sequencer has gone idle
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("last character while busy");

    // every other character comes out while a request is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("stray character outside a request");

    // a request only begins from start
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (char_code == itrd_pkg::CH_MINUS)
                || (char_code >= itrd_pkg::CH_ZERO && char_code <= itrd_pkg::CH_NINE)
                || (char_code >= itrd_pkg::CH_ALPHA && char_code <= itrd_pkg::CH_F))
        else $error("illegal character code");
`endif

endmodule

[rtl/itrd_ctrl.sv]
// ----------------------------------------------------------------------------
// itrd_ctrl
// Sequencer: divide until the quotient is zero, optional sign, then pop digits.
// ----------------------------------------------------------------------------
module itrd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  itrd_pkg::status_t status,
    output itrd_pkg::cmd_t    cmd,
    output logic              busy
);

    itrd_pkg::state_t state_reg;
    itrd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itrd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itrd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = itrd_pkg::ST_DIV;
                end
            end
            itrd_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = status.negative ? itrd_pkg::ST_SIGN : itrd_pkg::ST_POP;
                end
            end
            itrd_pkg::ST_SIGN:
            begin
                state_next = itrd_pkg::ST_POP;
            end
            itrd_pkg::ST_POP:
            begin
                if (status.pop_last)
                begin
                    state_next = itrd_pkg::ST_FLUSH;
                end
            end
            itrd_pkg::ST_FLUSH:
            begin
                state_next = itrd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = itrd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            itrd_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            itrd_pkg::ST_DIV:
            begin
                cmd.div = 1'b1;
            end
            itrd_pkg::ST_SIGN:
            begin
                cmd.sign = 1'b1;
            end
            itrd_pkg::ST_POP:
            begin
                cmd.pop = 1'b1;
            end
            itrd_pkg::ST_FLUSH:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

[rtl/itrd_datapath.sv]
// ----------------------------------------------------------------------------
// itrd_datapath
// Magnitude/radix capture, chunked long division, digit stack, char output.
// ----------------------------------------------------------------------------
module itrd_datapath #(
    parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  itrd_pkg::cmd_t                cmd,
    input  logic [VALUE_BITS-1:0]         value,
    input  logic [itrd_pkg::RADIX_W-1:0]  radix,
    output itrd_pkg::status_t             status,
    output logic                          strobe,
    output logic [itrd_pkg::CHAR_W-1:0]   char_code,
    output logic                          last
);

    localparam int CHUNK  = itrd_pkg::CHUNK_BITS;
    localparam int NCHUNK = (VALUE_BITS + CHUNK - 1) / CHUNK;
    localparam int QW     = NCHUNK * CHUNK;
    localparam int CIW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int SAW    = $clog2(MAX_DIGITS);
    localparam int CW     = $clog2(MAX_DIGITS + 1);
    localparam int DW     = itrd_pkg::DIGIT_W;
    localparam int RW     = itrd_pkg::RADIX_W;
    localparam int HW     = itrd_pkg::CHAR_W;

    logic [QW-1:0]  q_reg;
    logic [DW-1:0]  rem_reg;
    logic [RW-1:0]  radix_reg;
    logic [CIW-1:0] chunk_reg;
    logic [CIW-1:0] top_reg;
    logic [CW-1:0]  count_reg;
    logic           neg_reg;

    logic [DW-1:0]  stack_mem [MAX_DIGITS];
    logic [DW-1:0]  rd_reg;
    logic           pop_vld_reg;
    logic           pop_last_reg;

    logic           out_vld_reg;
    logic [HW-1:0]  out_char_reg;
    logic           out_last_reg;

    logic [VALUE_BITS-1:0] mag;
    logic [RW-1:0]         radix_sat;
    logic [CHUNK-1:0]      chunk_in;
    logic [CHUNK-1:0]      chunk_q;
    logic [DW-1:0]         rem_next;
    logic [QW-1:0]         q_upd;
    logic                  last_chunk;
    logic                  top_drop;
    logic [CW-1:0]         count_m1;
    logic                  push_ok;

    // Magnitude of the most negative value wraps to 2^(VALUE_BITS-1), as wanted
    assign mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

    always_comb
    begin
        radix_sat = radix;
        if (radix < itrd_pkg::RADIX_MIN)
        begin
            radix_sat = itrd_pkg::RADIX_MIN;
        end
        else if (radix > itrd_pkg::RADIX_MAX)
        begin
            radix_sat = itrd_pkg::RADIX_MAX;
        end
    end

    // One chunk of restoring division; remainder stays below radix (<= 16)
    always_comb
    begin
        logic [DW-1:0] r;
        logic [RW-1:0] t;
        chunk_in = q_reg[chunk_reg*CHUNK +: CHUNK];
        r        = rem_reg;
        chunk_q  = '0;
        for (int i = CHUNK - 1; i >= 0; i--)
        begin
            t = {r, chunk_in[i]};
            if (t >= radix_reg)
            begin
                r          = DW'(t - radix_reg);
                chunk_q[i] = 1'b1;
            end
            else
            begin
                r = DW'(t);
            end
        end
        rem_next = r;
    end

    always_comb
    begin
        q_upd = q_reg;
        q_upd[chunk_reg*CHUNK +: CHUNK] = chunk_q;
    end

    assign last_chunk = (chunk_reg == '0);
    assign top_drop   = (top_reg != '0) && (q_upd[top_reg*CHUNK +: CHUNK] == '0);
    assign count_m1   = count_reg - 1'b1;
    assign push_ok    = (count_reg < CW'(MAX_DIGITS));

    assign status.div_done = cmd.div && last_chunk && (q_upd == '0);
    assign status.negative = neg_reg;
    assign status.pop_last = (count_reg == CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg     <= '0;
            rem_reg   <= '0;
            chunk_reg <= '0;
            top_reg   <= '0;
            count_reg <= '0;
            neg_reg   <= 1'b0;
            radix_reg <= itrd_pkg::RADIX_MIN;
        end
        else if (cmd.load)
        begin
            q_reg     <= QW'(mag);
            rem_reg   <= '0;
            chunk_reg <= CIW'(NCHUNK - 1);
            top_reg   <= CIW'(NCHUNK - 1);
            count_reg <= '0;
            neg_reg   <= value[VALUE_BITS-1];
            radix_reg <= radix_sat;
        end
        else if (cmd.div)
        begin
            q_reg <= q_upd;
            if (last_chunk)
            begin
                // digit complete; restart from the top active chunk
                rem_reg   <= '0;
                top_reg   <= top_drop ? (top_reg - 1'b1) : top_reg;
                chunk_reg <= top_drop ? (top_reg - 1'b1) : top_reg;
                if (push_ok)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            else
            begin
                rem_reg   <= rem_next;
                chunk_reg <= chunk_reg - 1'b1;
            end
        end
        else if (cmd.pop)
        begin
            count_reg <= count_m1;
        end
    end

    // Digit stack; digits past capacity (most significant) are dropped
    always_ff @(posedge clk)
    begin
        if (cmd.div && last_chunk && push_ok)
        begin
            stack_mem[count_reg[SAW-1:0]] <= rem_next;
        end
        if (cmd.pop)
        begin
            rd_reg <= stack_mem[count_m1[SAW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_vld_reg  <= 1'b0;
            pop_last_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            pop_vld_reg  <= cmd.pop;
            pop_last_reg <= cmd.pop && status.pop_last;
            out_vld_reg  <= pop_vld_reg || cmd.sign;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sign)
        begin
            out_char_reg <= itrd_pkg::CH_MINUS;
            out_last_reg <= 1'b0;
        end
        else
        begin
            out_char_reg <= itrd_pkg::digit_char(rd_reg);
            out_last_reg <= pop_last_reg;
        end
    end

    assign strobe    = out_vld_reg;
    assign char_code = out_char_reg;
    assign last      = out_last_reg;

endmodule
